### hdl/adbp_pkg.sv
// Shared types and constants for the attribute database entry parser.
package adbp_pkg;

  // Fixed entry layout: size, flags and handle take six bytes.
  localparam logic [15:0] HDR_BYTES  = 16'd6;
  localparam logic [15:0] NARROW_END = 16'd8;
  localparam logic [15:0] WIDE_END   = 16'd22;
  localparam logic [15:0] MASK_RESET = 16'd512;

  // Configuration register word index.
  localparam logic REG_WIDE_ID_MASK = 1'b0;

  // Result kinds.
  localparam logic [2:0] KIND_HEADER    = 3'd0;
  localparam logic [2:0] KIND_VALUE     = 3'd1;
  localparam logic [2:0] KIND_INVALID   = 3'd2;
  localparam logic [2:0] KIND_END       = 3'd3;
  localparam logic [2:0] KIND_MALFORMED = 3'd4;

  // Parser phases.
  typedef enum logic [2:0] {
    PH_STOPPED,
    PH_HEAD,
    PH_SKIP,
    PH_ID_NARROW,
    PH_ID_WIDE,
    PH_VAL_NARROW,
    PH_VAL_WIDE
  } phase_t;

  // One input byte of the database.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } in_item_t;

  // One parser result.
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] entry_flags;
    logic        is_wide_id;
    logic [63:0] id_high;
    logic [63:0] id_low;
    logic [15:0] value_length;
    logic [7:0]  value_byte;
    logic        last;
  } out_item_t;

endpackage

### hdl/adbp_parser.sv
// Entry parsing state and the per-byte decode that forms one result.
module adbp_parser
  import adbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  in_item_t    item,
  input  logic [15:0] wide_id_flag_mask,
  output logic        res_valid,
  output out_item_t   res
);

  phase_t            phase, phase_next;
  logic [15:0]       byte_offset, byte_offset_next;
  logic [15:0]       entry_length, entry_length_next;
  logic [15:0]       flags_word, flags_word_next;
  logic [1:0][63:0]  id_acc, id_acc_next;

  logic [16:0] off_plus1;
  logic [15:0] len_full;
  logic        wide;
  logic [15:0] need;
  logic [3:0]  id_idx;
  logic [15:0] vlen;
  logic        at_end;
  logic [7:0]  b;

  assign b         = item.data_byte;
  assign off_plus1 = {1'b0, byte_offset} + 17'd1;
  assign len_full  = {b, entry_length[7:0]};
  assign id_idx    = byte_offset[3:0] - HDR_BYTES[3:0];
  assign at_end    = off_plus1 >= {1'b0, entry_length};

  // Width of the UUID: taken from the flags on the last handle byte, then from the phase.
  always_comb begin
    if (phase == PH_HEAD) begin
      wide = (flags_word & wide_id_flag_mask) != 16'd0;
    end else begin
      wide = (phase == PH_ID_WIDE) || (phase == PH_VAL_WIDE);
    end
  end

  assign need = wide ? WIDE_END : NARROW_END;
  assign vlen = entry_length - need;

  // Next state and result for the byte being processed.
  always_comb begin
    phase_next        = phase;
    byte_offset_next  = byte_offset + 16'd1;
    entry_length_next = entry_length;
    flags_word_next   = flags_word;
    id_acc_next       = id_acc;
    res_valid         = 1'b0;
    res               = '0;

    if (item.start_req) begin
      // Version byte: restart from a clean state.
      phase_next        = PH_HEAD;
      byte_offset_next  = 16'd0;
      entry_length_next = 16'd0;
      flags_word_next   = 16'd0;
      id_acc_next       = '0;
    end else begin
      case (phase)
        PH_HEAD: begin
          case (byte_offset)
            16'd0: begin
              entry_length_next = {8'd0, b};
              flags_word_next   = 16'd0;
              id_acc_next       = '0;
            end
            16'd1: begin
              entry_length_next = len_full;
              if (len_full < HDR_BYTES) begin
                res_valid        = 1'b1;
                res.kind         = (len_full == 16'd0) ? KIND_END : KIND_MALFORMED;
                res.last         = 1'b1;
                phase_next       = PH_STOPPED;
                byte_offset_next = 16'd0;
              end
            end
            16'd2: flags_word_next = {8'd0, b};
            16'd3: flags_word_next = {b, flags_word[7:0]};
            16'd5: begin
              if (entry_length < need) begin
                // Entry too short to hold its UUID.
                res_valid       = 1'b1;
                res.kind        = KIND_INVALID;
                res.entry_flags = flags_word;
                res.is_wide_id  = wide;
                res.last        = 1'b1;
                if (entry_length == HDR_BYTES) begin
                  phase_next       = PH_HEAD;
                  byte_offset_next = 16'd0;
                end else begin
                  phase_next       = PH_SKIP;
                  byte_offset_next = HDR_BYTES;
                end
              end else begin
                phase_next = wide ? PH_ID_WIDE : PH_ID_NARROW;
              end
            end
            default: ;
          endcase
        end

        PH_SKIP: begin
          if (at_end) begin
            phase_next       = PH_HEAD;
            byte_offset_next = 16'd0;
          end
        end

        PH_ID_NARROW, PH_ID_WIDE: begin
          // Shift the UUID byte into its little-endian place.
          id_acc_next[id_idx[3]][{id_idx[2:0], 3'b000} +: 8] = b;
          if (off_plus1 >= {1'b0, need}) begin
            res_valid        = 1'b1;
            res.kind         = KIND_HEADER;
            res.entry_flags  = flags_word;
            res.is_wide_id   = wide;
            res.id_high      = id_acc_next[1];
            res.id_low       = id_acc_next[0];
            res.value_length = vlen;
            res.last         = vlen == 16'd0;
            if (vlen == 16'd0) begin
              phase_next       = PH_HEAD;
              byte_offset_next = 16'd0;
            end else begin
              phase_next = wide ? PH_VAL_WIDE : PH_VAL_NARROW;
            end
          end
        end

        PH_VAL_NARROW, PH_VAL_WIDE: begin
          res_valid        = 1'b1;
          res.kind         = KIND_VALUE;
          res.entry_flags  = flags_word;
          res.is_wide_id   = wide;
          res.id_high      = id_acc[1];
          res.id_low       = id_acc[0];
          res.value_length = vlen;
          res.value_byte   = b;
          res.last         = at_end;
          if (at_end) begin
            phase_next       = PH_HEAD;
            byte_offset_next = 16'd0;
          end
        end

        default: begin
          byte_offset_next = byte_offset;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_STOPPED;
      byte_offset  <= 16'd0;
      entry_length <= 16'd0;
      flags_word   <= 16'd0;
      id_acc       <= '0;
    end else if (advance) begin
      phase        <= phase_next;
      byte_offset  <= byte_offset_next;
      entry_length <= entry_length_next;
      flags_word   <= flags_word_next;
      id_acc       <= id_acc_next;
    end
  end

endmodule

### hdl/attribute_database_entry_parser_core.sv
// Registers: a byte is registered in the input register on transfer, and its result is
// registered in the result register when the byte advances out of the input register.
// Throughput: one byte per cycle while out_stall is low; a stalled result holds the byte
// in the input register, and in_stall follows out_stall in the same cycle.
// Reset: synchronous active-high rst stops parsing until a start byte, empties both
// registers and sets the wide UUID mask to 512.
// Top level of the attribute database entry parser.
module attribute_database_entry_parser_core
  import adbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_q_valid;
  in_item_t    in_q;
  logic        advance;
  logic        res_valid;
  out_item_t   res;
  logic [15:0] wide_id_flag_mask;

  // The held byte moves on when the result register is free or draining.
  assign advance  = in_q_valid && (!out_valid || !out_stall);
  assign in_stall = in_q_valid && !advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_q <= in_data;
    end
  end

  adbp_parser u_parser (
    .clk               (clk),
    .rst               (rst),
    .advance           (advance),
    .item              (in_q),
    .wide_id_flag_mask (wide_id_flag_mask),
    .res_valid         (res_valid),
    .res               (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res_valid;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_data <= res;
    end
  end

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_WIDE_ID_MASK) ? {16'd0, wide_id_flag_mask} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_id_flag_mask <= MASK_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_WIDE_ID_MASK) begin
      wide_id_flag_mask <= pwdata[15:0];
    end
  end

endmodule

### hdl/adbp_checker.sv
// Port-level checks for the parser core and their binding to it.
module adbp_checker
  import adbp_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result transfer holds its payload.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Only value results carry a value byte.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind != KIND_VALUE |-> out_data.value_byte == 8'd0)
    else $error("value byte outside a value result");

  // End and malformed stops are bare, final results.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.kind == KIND_END || out_data.kind == KIND_MALFORMED)
    |-> out_data.last && out_data.entry_flags == 16'd0 && out_data.id_low == 64'd0)
    else $error("stop result carries entry fields");

  // A header closes its entry exactly when no value bytes follow.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_HEADER
    |-> out_data.last == (out_data.value_length == 16'd0))
    else $error("header last flag mismatch");

  // A 16-bit UUID leaves the upper half zero.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_HEADER && !out_data.is_wide_id
    |-> out_data.id_high == 64'd0)
    else $error("narrow UUID has upper bits");

endmodule

bind attribute_database_entry_parser_core adbp_checker u_adbp_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/sv/tb.sv
// Self-checking testbench for the attribute database entry parser core.
`timescale 1ns / 1ps

module tb;
  import adbp_pkg::*;

  localparam int         CYCLE_LIMIT  = 500000;
  localparam int         BYTES_PER_CFG = 260;
  localparam logic [2:0] MASK_ADDR    = {REG_WIDE_ID_MASK, 2'b00};

  // One byte handed to the driver, with an optional result typed in by hand.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
    logic       fixed;
    out_item_t  res;
  } db_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  attribute_database_entry_parser_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Parser state mirrored by the predictor.
  phase_t      cur_phase = PH_STOPPED;
  logic [15:0] ofs = '0;
  logic [15:0] ent_len = '0;
  logic [15:0] flag_word = '0;
  logic [63:0] uuid_acc [2] = '{64'd0, 64'd0};
  logic [15:0] id_mask = MASK_RESET;

  out_item_t pending_results [$];
  db_byte_t  sent_bytes [$];
  int        mismatches = 0;
  int        cycles = 0;
  int        bytes_sent = 0;
  int        burst_left = 0;
  int        stall_left = 0;
  int        stall_mode = 0;
  db_byte_t  dir_rows [25];

  initial begin
    forever #2 clk = ~clk;
  end

  // Build one result from the current entry fields.
  function automatic out_item_t parse_result(input logic [2:0] kind, input logic wide,
                                             input logic with_id, input logic [15:0] vlen,
                                             input logic [7:0] vbyte, input logic fin);
    out_item_t r;
    r = '0;
    r.kind         = kind;
    r.entry_flags  = (kind <= KIND_INVALID) ? flag_word : 16'd0;
    r.is_wide_id   = (kind <= KIND_INVALID) && wide;
    r.id_high      = with_id ? uuid_acc[1] : 64'd0;
    r.id_low       = with_id ? uuid_acc[0] : 64'd0;
    r.value_length = vlen;
    r.value_byte   = vbyte;
    r.last         = fin;
    return r;
  endfunction

  // Predict the effect of one database byte; returns 1 when it yields a result.
  function automatic logic parse_byte(input in_item_t it, output out_item_t res);
    logic        wide;
    logic [15:0] need;
    logic [15:0] vlen;
    logic [3:0]  idx;
    logic        fin;
    res = '0;
    if (it.start_req) begin
      cur_phase   = PH_HEAD;
      ofs         = '0;
      ent_len     = '0;
      flag_word   = '0;
      uuid_acc[0] = '0;
      uuid_acc[1] = '0;
      return 1'b0;
    end
    case (cur_phase)
      PH_HEAD: begin
        case (ofs)
          16'd0: begin
            ent_len     = {8'h00, it.data_byte};
            flag_word   = '0;
            uuid_acc[0] = '0;
            uuid_acc[1] = '0;
          end
          16'd1: begin
            ent_len[15:8] = it.data_byte;
            // A zero size ends the database; any other short size is malformed.
            if (ent_len < HDR_BYTES) begin
              res = parse_result((ent_len == 16'd0) ? KIND_END : KIND_MALFORMED,
                                 1'b0, 1'b0, 16'd0, 8'd0, 1'b1);
              cur_phase = PH_STOPPED;
              ofs = '0;
              return 1'b1;
            end
          end
          16'd2: flag_word = {8'h00, it.data_byte};
          16'd3: flag_word[15:8] = it.data_byte;
          16'd5: begin
            // The wide mask is sampled on the last handle byte.
            wide = (flag_word & id_mask) != 16'd0;
            need = wide ? WIDE_END : NARROW_END;
            if (ent_len < need) begin
              res = parse_result(KIND_INVALID, wide, 1'b0, 16'd0, 8'd0, 1'b1);
              if (ent_len == HDR_BYTES) begin
                cur_phase = PH_HEAD;
                ofs = '0;
              end else begin
                cur_phase = PH_SKIP;
                ofs = HDR_BYTES;
              end
              return 1'b1;
            end
            if (wide) begin
              cur_phase = PH_ID_WIDE;
            end else begin
              cur_phase = PH_ID_NARROW;
            end
          end
          default: ;
        endcase
        ofs = ofs + 16'd1;
        return 1'b0;
      end
      PH_SKIP: begin
        if (int'(ofs) + 1 >= int'(ent_len)) begin
          cur_phase = PH_HEAD;
          ofs = '0;
        end else begin
          ofs = ofs + 16'd1;
        end
        return 1'b0;
      end
      PH_ID_NARROW, PH_ID_WIDE: begin
        wide = (cur_phase == PH_ID_WIDE);
        need = wide ? WIDE_END : NARROW_END;
        idx  = 4'(ofs - HDR_BYTES);
        uuid_acc[idx[3]][8 * idx[2:0] +: 8] = it.data_byte;
        if (int'(ofs) + 1 >= int'(need)) begin
          vlen = ent_len - need;
          res = parse_result(KIND_HEADER, wide, 1'b1, vlen, 8'd0, vlen == 16'd0);
          if (vlen == 16'd0) begin
            cur_phase = PH_HEAD;
            ofs = '0;
          end else begin
            if (wide) begin
              cur_phase = PH_VAL_WIDE;
            end else begin
              cur_phase = PH_VAL_NARROW;
            end
            ofs = ofs + 16'd1;
          end
          return 1'b1;
        end
        ofs = ofs + 16'd1;
        return 1'b0;
      end
      PH_VAL_NARROW, PH_VAL_WIDE: begin
        wide = (cur_phase == PH_VAL_WIDE);
        need = wide ? WIDE_END : NARROW_END;
        fin  = int'(ofs) + 1 >= int'(ent_len);
        res = parse_result(KIND_VALUE, wide, 1'b1, ent_len - need, it.data_byte, fin);
        if (fin) begin
          cur_phase = PH_HEAD;
          ofs = '0;
        end else begin
          ofs = ofs + 16'd1;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // Result that closes an entry or the database: only kind, flags, width and last set.
  function automatic out_item_t closing_result(input logic [2:0] kind, input logic [15:0] flg,
                                               input logic wide);
    out_item_t r;
    r = '0;
    r.kind        = kind;
    r.entry_flags = flg;
    r.is_wide_id  = wide;
    r.last        = 1'b1;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  // Predict on every input transfer, then compare every output transfer.
  always @(posedge clk) begin : result_check
    out_item_t calc;
    out_item_t want;
    out_item_t got;
    db_byte_t  row;
    logic      made;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        made = parse_byte(in_data, calc);
        row = sent_bytes.pop_front();
        if (row.fixed) begin
          pending_results.push_back(row.res);
        end else if (made) begin
          pending_results.push_back(calc);
        end
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: kind %0d", got.kind);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 64'(want.kind), 64'(got.kind));
          check_field("entry_flags", 64'(want.entry_flags), 64'(got.entry_flags));
          check_field("is_wide_id", 64'(want.is_wide_id), 64'(got.is_wide_id));
          check_field("id_high", want.id_high, got.id_high);
          check_field("id_low", want.id_low, got.id_low);
          check_field("value_length", 64'(want.value_length), 64'(got.value_length));
          check_field("value_byte", 64'(want.value_byte), 64'(got.value_byte));
          check_field("last", 64'(want.last), 64'(got.last));
        end
      end
    end
  end

  // Receiver stall: a new pattern chosen at random after each random stretch, including no stalls at all.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(50, 300);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= ($urandom_range(0, 99) < 75);
      default: out_stall <= ((cycles % 5) < 2);
    endcase
  end

  // Cycle count and watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** attribute_database_entry_parser_core: FAILED **");
      $finish;
    end
  end

  // Offer one byte and wait for its transfer; the sender works in bursts with gaps.
  task automatic offer_byte(input db_byte_t row);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(10, 30)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(100, 300);
      end else begin
        burst_left = $urandom_range(1, 20);
      end
    end
    sent_bytes.push_back(row);
    in_data  <= {row.data_byte, row.start_req};
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    bytes_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input logic s);
    db_byte_t row;
    row = '0;
    row.data_byte = b;
    row.start_req = s;
    offer_byte(row);
  endtask

  task automatic send_random(input int n);
    repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
  endtask

  // Stop sending and wait until every expected result has been transferred.
  task automatic drain_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write the wide UUID mask over the config port and read it back.
  task automatic set_wide_mask(input logic [15:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MASK_ADDR;
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    id_mask = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    psel    <= 1'b1;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== value) begin
      $error("wide_id_flag_mask: expected 0x%0h, got 0x%0h", value, prdata[15:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // One database: version byte, then some entries and an ending of random shape, or noise.
  task automatic send_database();
    logic [15:0] flg;
    logic [15:0] sz;
    logic        wide;
    int          need;
    int          vlen;
    int          roll;
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    // A few databases are pure noise after the version byte.
    if ($urandom_range(0, 19) == 0) begin
      send_random($urandom_range(4, 20));
      return;
    end
    repeat ($urandom_range(0, 6)) begin
      flg  = 16'($urandom_range(0, 65535));
      wide = (flg & id_mask) != 16'd0;
      need = wide ? int'(WIDE_END) : int'(NARROW_END);
      if ($urandom_range(0, 99) < 85) begin
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
          vlen = $urandom_range(0, 6);
        end else if (roll < 97) begin
          vlen = $urandom_range(7, 40);
        end else begin
          vlen = $urandom_range(240, 280);
        end
        sz = 16'(need + vlen);
      end else begin
        sz = 16'($urandom_range(int'(HDR_BYTES), need - 1));
      end
      send_byte(sz[7:0], 1'b0);
      send_byte(sz[15:8], 1'b0);
      send_byte(flg[7:0], 1'b0);
      send_byte(flg[15:8], 1'b0);
      send_random(int'(sz) - 4);
    end
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
    end else if (roll < 70) begin
      send_byte(8'($urandom_range(1, 5)), 1'b0);
      send_byte(8'h00, 1'b0);
    end else if (roll < 85) begin
      // Broken entry: the next version byte cuts it off.
      send_byte(8'($urandom_range(6, 60)), 1'b0);
      send_random($urandom_range(0, 20));
      return;
    end else begin
      return;
    end
    // Bytes after the end are ignored until the next start.
    send_random($urandom_range(0, 4));
  endtask

  initial begin
    logic [15:0] masks [5];
    logic [15:0] mask_val;
    int          mark;
    masks = '{MASK_RESET, 16'h0000, 16'hFFFF, 16'h0001, 16'h0000};

    // Directed bytes; closing results that are plain to see are typed in.
    dir_rows = '{
      '{8'hFF, 1'b0, 1'b0, '0},  // stopped after reset
      '{8'hA5, 1'b1, 1'b0, '0},  // version byte
      '{8'h09, 1'b0, 1'b0, '0},  // narrow entry, one value byte
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFD, 1'b0, 1'b0, '0},
      '{8'h34, 1'b0, 1'b0, '0},
      '{8'h12, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},
      '{8'hFF, 1'b0, 1'b0, '0},  // header
      '{8'h00, 1'b0, 1'b0, '0},  // value byte
      '{8'h06, 1'b0, 1'b0, '0},  // wide entry too short for its UUID
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h02, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h00, 1'b0, 1'b1, closing_result(KIND_INVALID, 16'h0200, 1'b1)},
      '{8'h0A, 1'b0, 1'b0, '0},  // entry cut off by a start
      '{8'h00, 1'b0, 1'b0, '0},
      '{8'h3C, 1'b1, 1'b0, '0},
      '{8'h05, 1'b0, 1'b0, '0},  // malformed size
      '{8'h00, 1'b0, 1'b1, closing_result(KIND_MALFORMED, 16'h0000, 1'b0)},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h00, 1'b0, 1'b0, '0},  // end of database
      '{8'h00, 1'b0, 1'b1, closing_result(KIND_END, 16'h0000, 1'b0)}
    };

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) offer_byte(dir_rows[i]);

    // Random databases under several mask settings.
    for (int p = 0; p < 5; p++) begin
      drain_results();
      repeat (6) @(posedge clk);
      mask_val = (p == 4) ? 16'($urandom_range(1, 65534)) : masks[p];
      set_wide_mask(mask_val);
      mark = bytes_sent;
      while (bytes_sent - mark < BYTES_PER_CFG) begin
        if ($urandom_range(0, 99) < 8) begin
          drain_results();
        end
        send_database();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("** attribute_database_entry_parser_core: PASSED **");
    end else begin
      $display("** attribute_database_entry_parser_core: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
hdl/adbp_pkg.sv
hdl/adbp_parser.sv
hdl/attribute_database_entry_parser_core.sv
hdl/adbp_checker.sv
tb/sv/tb.sv
